### rtl/tsp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tone sequence player.
// No dependencies; imported by the core.
package tsp_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  localparam int CNT_W = 13;

  localparam logic [2:0]       IDLE_LEVEL  = 3'd7;
  localparam logic [CNT_W-1:0] START_DELAY = 13'd10;
  localparam logic [CNT_W-1:0] STEP_EXTRA  = 13'd5;
  localparam logic [6:0]       DUTY_NORMAL = 7'd50;
  localparam logic [6:0]       DUTY_LOW    = 7'd2;

  // One pattern memory entry, 25 bits.
  typedef struct packed {
    logic        end_mark;
    logic [11:0] duration;
    logic [11:0] freq;
  } entry_t;

  typedef struct packed {
    logic        start_rejected;
    logic        tone_on;
    logic [11:0] tone_freq;
    logic [6:0]  duty_percent;
    logic        playing;
    logic        driving;
    logic [2:0]  current_level;
  } result_t;

endpackage

### rtl/tone_sequence_player_core.sv
`timescale 1ns / 1ps
// Tone sequence player: pattern memory, priority start, tick-driven stepping.
// A result is registered in the output register, or in the skid entry if the output stalls.
// Throughput: one request per cycle while in_stall is low; the pattern RAM is read every
// cycle at the next pointer, so the entry for a step is ready before the tick that needs it.
// Reset (rst_n low, synchronous): idle at level 7, tone off, outputs empty;
// pattern memory contents are not cleared.
module tone_sequence_player_core
  import tsp_pkg::*;
#(
  parameter int PATTERN_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_address,
  input  logic [11:0] in_entry_freq,
  input  logic [11:0] in_entry_duration,
  input  logic        in_entry_end,
  input  logic [2:0]  in_priority_level,
  input  logic        in_honor_volume,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_start_rejected,
  output logic        out_tone_on,
  output logic [11:0] out_tone_freq,
  output logic [6:0]  out_duty_percent,
  output logic        out_playing,
  output logic        out_driving,
  output logic [2:0]  out_current_level
);

  localparam int AW = $clog2(PATTERN_DEPTH);

  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       level_r, level_nxt;
  logic             active_r, active_nxt;
  logic             driving_r, driving_nxt;
  logic             honored_r, honored_nxt;
  logic [11:0]      freq_r, freq_nxt;
  logic             tone_en_r, tone_en_nxt;
  logic             low_duty_r, low_duty_nxt;
  logic             bass_r;

  logic             byp_sel_r;
  entry_t           byp_data_r;
  entry_t           ram_q;
  entry_t           cur_entry;
  entry_t           wr_entry;

  result_t          out_r, skid_r, res;
  logic             out_valid_r, skid_valid_r;

  logic             in_fire, out_fire;
  logic             wr_en, rejected, do_shut;
  logic [7:0]       addr_mod;
  logic [AW-1:0]    addr_idx;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;

  // Address modulo depth by conditional subtraction of shifted depths.
  always_comb begin
    addr_mod = in_address;
    for (int k = 3; k >= 0; k--) begin
      if (32'(addr_mod) >= (PATTERN_DEPTH << k)) begin
        addr_mod = addr_mod - 8'(PATTERN_DEPTH << k);
      end
    end
  end
  assign addr_idx = AW'(addr_mod);

  assign wr_entry = '{end_mark: in_entry_end, duration: in_entry_duration,
                      freq: in_entry_freq};

  // Entry at ptr_r: RAM data, or a write that hit the read address last cycle.
  assign cur_entry = byp_sel_r ? byp_data_r : ram_q;

  always_comb begin
    ptr_nxt      = ptr_r;
    cnt_nxt      = cnt_r;
    level_nxt    = level_r;
    active_nxt   = active_r;
    driving_nxt  = driving_r;
    honored_nxt  = honored_r;
    freq_nxt     = freq_r;
    tone_en_nxt  = tone_en_r;
    low_duty_nxt = low_duty_r;
    wr_en        = 1'b0;
    rejected     = 1'b0;
    do_shut      = 1'b0;
    if (in_fire) begin
      case (cmd_t'(in_cmd))
        CMD_WRITE: begin
          wr_en = 1'b1;
        end
        CMD_START: begin
          if (in_priority_level > level_r) begin
            rejected = 1'b1;
          end else begin
            ptr_nxt      = addr_idx;
            cnt_nxt      = START_DELAY;
            level_nxt    = in_priority_level;
            active_nxt   = 1'b1;
            driving_nxt  = 1'b0;
            honored_nxt  = in_honor_volume;
            freq_nxt     = '0;
            tone_en_nxt  = 1'b0;
            low_duty_nxt = 1'b0;
          end
        end
        CMD_STOP: begin
          do_shut = 1'b1;
        end
        CMD_TICK: begin
          if (active_r) begin
            if (cnt_r > CNT_W'(1)) begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end else if (cur_entry.end_mark) begin
              do_shut = 1'b1;
            end else begin
              driving_nxt = 1'b1;
              if (cur_entry.freq != 12'd0) begin
                tone_en_nxt  = 1'b1;
                freq_nxt     = cur_entry.freq;
                low_duty_nxt = honored_r && bass_r;
              end else begin
                tone_en_nxt  = 1'b0;
                freq_nxt     = '0;
                low_duty_nxt = 1'b0;
              end
              cnt_nxt = CNT_W'(cur_entry.duration) + STEP_EXTRA;
              ptr_nxt = (ptr_r == AW'(PATTERN_DEPTH - 1)) ? '0 : ptr_r + AW'(1);
            end
          end
        end
        default: ;
      endcase
    end
    if (do_shut) begin
      ptr_nxt      = '0;
      cnt_nxt      = '0;
      level_nxt    = IDLE_LEVEL;
      active_nxt   = 1'b0;
      driving_nxt  = 1'b0;
      freq_nxt     = '0;
      tone_en_nxt  = 1'b0;
      low_duty_nxt = 1'b0;
    end
  end

  always_comb begin
    res.start_rejected = rejected;
    res.tone_on        = tone_en_nxt;
    res.tone_freq      = tone_en_nxt ? freq_nxt : 12'd0;
    res.duty_percent   = !tone_en_nxt ? 7'd0 : (low_duty_nxt ? DUTY_LOW : DUTY_NORMAL);
    res.playing        = active_nxt;
    res.driving        = driving_nxt;
    res.current_level  = level_nxt;
  end

  tsp_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(PATTERN_DEPTH)
  ) u_pattern_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(addr_idx),
    .wr_data(wr_entry),
    .rd_addr(ptr_nxt),
    .rd_data(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r        <= '0;
      cnt_r        <= '0;
      level_r      <= IDLE_LEVEL;
      active_r     <= 1'b0;
      driving_r    <= 1'b0;
      honored_r    <= 1'b0;
      freq_r       <= '0;
      tone_en_r    <= 1'b0;
      low_duty_r   <= 1'b0;
      bass_r       <= 1'b0;
      byp_sel_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      ptr_r      <= ptr_nxt;
      cnt_r      <= cnt_nxt;
      level_r    <= level_nxt;
      active_r   <= active_nxt;
      driving_r  <= driving_nxt;
      honored_r  <= honored_nxt;
      freq_r     <= freq_nxt;
      tone_en_r  <= tone_en_nxt;
      low_duty_r <= low_duty_nxt;
      if (cfg_wr_en) begin
        bass_r <= cfg_wr_data;
      end
      byp_sel_r <= wr_en && (addr_idx == ptr_nxt);
      // Output register with one skid entry behind it.
      if (skid_valid_r) begin
        if (out_fire) begin
          skid_valid_r <= 1'b0;
        end
      end else if (in_fire) begin
        if (out_valid_r && out_stall) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= wr_entry;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && out_stall) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_start_rejected = out_r.start_rejected;
  assign out_tone_on        = out_r.tone_on;
  assign out_tone_freq      = out_r.tone_freq;
  assign out_duty_percent   = out_r.duty_percent;
  assign out_playing        = out_r.playing;
  assign out_driving        = out_r.driving;
  assign out_current_level  = out_r.current_level;

endmodule

### rtl/tsp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsp_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/tsp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the tone sequence player core.
// No dependencies; bound to tone_sequence_player_core below.
module tsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_start_rejected,
  input logic        out_tone_on,
  input logic [11:0] out_tone_freq,
  input logic [6:0]  out_duty_percent,
  input logic        out_playing,
  input logic        out_driving,
  input logic [2:0]  out_current_level
);

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tone_freq) &&
      $stable(out_current_level) && $stable(out_start_rejected))
    else $error("stalled result changed");

  // Silence means no frequency and no duty.
  a_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tone_on |-> out_tone_freq == 12'd0 && out_duty_percent == 7'd0)
    else $error("silent result carries frequency or duty");

  // Idle means idle level, nothing driven.
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_playing |->
      out_current_level == 3'd7 && !out_driving && !out_tone_on)
    else $error("idle result with running state");

endmodule

bind tone_sequence_player_core tsp_checker u_tsp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_start_rejected(out_start_rejected),
  .out_tone_on       (out_tone_on),
  .out_tone_freq     (out_tone_freq),
  .out_duty_percent  (out_duty_percent),
  .out_playing       (out_playing),
  .out_driving       (out_driving),
  .out_current_level (out_current_level)
);
